>>> rtl/core/mts_pkg.sv
`timescale 1ns / 1ps
package mts_pkg;

  localparam int DataWidth = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

  typedef struct packed {
    logic                        command;
    logic signed [DataWidth-1:0] push_value;
  } stack_req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] top_value;
    logic signed [DataWidth-1:0] min_value;
    logic                        is_empty;
    logic [1:0]                  status;
  } stack_res_t;

  typedef struct packed {
    logic push_ok;
    logic pop_ok;
    logic refuse_empty;
    logic refuse_full;
    logic pop_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

>>> rtl/core/mts_control.sv
`timescale 1ns / 1ps
module mts_control (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             command,
  input  mts_pkg::dp_stat_t stat,
  output mts_pkg::dp_ctrl_t ctrl,
  output logic             busy,
  output logic             done
);
  import mts_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  always_comb begin
    ctrl.push_ok      = accept && (command == CMD_PUSH) && !stat.full;
    ctrl.refuse_full  = accept && (command == CMD_PUSH) && stat.full;
    ctrl.pop_ok       = accept && (command == CMD_POP) && !stat.empty;
    ctrl.refuse_empty = accept && (command == CMD_POP) && stat.empty;
    ctrl.pop_load     = (state == ST_POP);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ctrl.pop_ok) begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctrl.push_ok || ctrl.refuse_full || ctrl.refuse_empty || ctrl.pop_load;
    end
  end

endmodule

>>> rtl/core/mts_datapath.sv
`timescale 1ns / 1ps
module mts_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  mts_pkg::stack_req_t request,
  input  mts_pkg::dp_ctrl_t  ctrl,
  output mts_pkg::dp_stat_t  stat,
  output mts_pkg::stack_res_t result
);
  import mts_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [DataWidth-1:0] value_mem  [STACK_DEPTH];
  logic [DataWidth-1:0] minima_mem [STACK_DEPTH];

  logic [CW-1:0] count;
  logic [CW-1:0] mcount;
  logic signed [DataWidth-1:0] top_reg;
  logic signed [DataWidth-1:0] min_reg;
  logic signed [DataWidth-1:0] rd_val;
  logic signed [DataWidth-1:0] rd_min;

  logic          take_min;
  logic [CW-1:0] push_mcount;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] cnt_dec2;
  logic [CW-1:0] pop_mcount;
  logic [CW-1:0] pop_mcount_dec;
  logic          pop_min;
  logic signed [DataWidth-1:0] min_shown;

  assign stat.full  = (count == CW'(STACK_DEPTH));
  assign stat.empty = (count == '0);

  assign take_min    = (mcount == '0) || (count == '0) || (request.push_value <= min_reg);
  assign push_mcount = (count == '0) ? '0 : mcount;

  assign cnt_dec        = count - CW'(1);
  assign cnt_dec2       = count - CW'(2);
  assign pop_min        = (mcount != '0) && (top_reg == min_reg);
  assign pop_mcount     = (cnt_dec == '0) ? '0 : (pop_min ? mcount - CW'(1) : mcount);
  assign pop_mcount_dec = pop_mcount - CW'(1);

  assign min_shown = (mcount == '0) ? '0 : min_reg;

  always_ff @(posedge clk) begin
    if (ctrl.push_ok) begin
      value_mem[count[AW-1:0]] <= request.push_value;
      if (take_min) begin
        minima_mem[push_mcount[AW-1:0]] <= request.push_value;
      end
    end
    rd_val <= value_mem[cnt_dec2[AW-1:0]];
    rd_min <= minima_mem[pop_mcount_dec[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      mcount <= '0;
    end else if (ctrl.push_ok) begin
      count <= count + CW'(1);
      if (take_min) begin
        mcount <= push_mcount + CW'(1);
      end
    end else if (ctrl.pop_ok) begin
      count  <= cnt_dec;
      mcount <= pop_mcount;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_ok) begin
      top_reg          <= request.push_value;
      result.top_value <= request.push_value;
      result.is_empty  <= 1'b0;
      result.status    <= STATUS_OK;
      if (take_min) begin
        min_reg          <= request.push_value;
        result.min_value <= request.push_value;
      end else begin
        result.min_value <= min_reg;
      end
    end else if (ctrl.refuse_full) begin
      result.top_value <= top_reg;
      result.min_value <= min_shown;
      result.is_empty  <= 1'b0;
      result.status    <= STATUS_PUSH_FULL;
    end else if (ctrl.refuse_empty) begin
      result.top_value <= '0;
      result.min_value <= '0;
      result.is_empty  <= 1'b1;
      result.status    <= STATUS_POP_EMPTY;
    end else if (ctrl.pop_load) begin
      top_reg       <= rd_val;
      min_reg       <= rd_min;
      result.status <= STATUS_OK;
      if (count == '0) begin
        result.top_value <= '0;
        result.min_value <= '0;
        result.is_empty  <= 1'b1;
      end else begin
        result.top_value <= rd_val;
        result.min_value <= (mcount == '0) ? '0 : rd_min;
        result.is_empty  <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/min_tracking_stack.sv
`timescale 1ns / 1ps
// Stack of signed 32-bit values that also reports its running minimum.
// A command word is taken on request at a rising edge where start is high
// and busy is low; command selects push or pop, push_value is the operand.
// Every command word returns one result word on result, marked by done for
// exactly one cycle. The result carries the new top, the minimum of all held
// values, an empty flag and a status: ok, pop on empty refused, or push on
// full refused. Refused commands leave the stack unchanged.
// A push, or any refused command, answers in the cycle after it is taken and
// busy stays low, so one such command can be taken every cycle.
// An accepted pop holds busy high for one cycle, in the ST_POP state, and
// answers when that state ends, because the new top and minimum are read back
// from the two on-chip stores, whose read data are registered.
// The receiver cannot stall; each result must be captured while done is high.
// Reset clears both fill counts, so the stack starts empty; the stores
// themselves are not cleared and need no clearing pass.
module min_tracking_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mts_pkg::stack_req_t request,
  output logic                done,
  output mts_pkg::stack_res_t result
);
  import mts_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  mts_control u_control (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .stat    (stat),
    .ctrl    (ctrl),
    .busy    (busy),
    .done    (done)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctrl    (ctrl),
    .stat    (stat),
    .result  (result)
  );

  a_pop_answers: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop_ok |=> busy ##1 (done && !busy))
    else $error("accepted pop did not answer after one busy cycle");

  a_push_answers: assert property (@(posedge clk) disable iff (rst)
    (ctrl.push_ok || ctrl.refuse_full || ctrl.refuse_empty) |=> (done && !busy))
    else $error("push or refused command did not answer in the next cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |-> (result.top_value == '0 && result.min_value == '0))
    else $error("empty result carries nonzero top or minimum");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_PUSH_FULL) |-> !result.is_empty)
    else $error("refused push reported an empty stack");

endmodule

>>> verif/min_tracking_stack_test.sv
`timescale 1ns / 1ps
module min_tracking_stack_test;
  import mts_pkg::*;

  localparam int Depth = 64;
  localparam int CycleLimit = 200000;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  stack_req_t request;
  logic       done;
  stack_res_t result;

  min_tracking_stack #(
    .STACK_DEPTH(Depth)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  logic signed [DataWidth-1:0] held_values [Depth];
  logic signed [DataWidth-1:0] held_minima [Depth];
  int         value_depth = 0;
  int         minima_depth = 0;
  stack_res_t expected_results [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         gap_max = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Applies one command word to the shadow stack and returns the word that
  // the block should answer with.
  function automatic stack_res_t apply_command(input stack_req_t w);
    stack_res_t r;
    logic signed [DataWidth-1:0] popped;
    r.status = STATUS_OK;
    if (w.command == CMD_PUSH) begin
      if (value_depth >= Depth) begin
        r.status = STATUS_PUSH_FULL;
      end else begin
        if (minima_depth == 0 || value_depth == 0 ||
            w.push_value <= held_minima[minima_depth-1]) begin
          if (value_depth == 0) minima_depth = 0;
          if (minima_depth < Depth) begin
            held_minima[minima_depth] = w.push_value;
            minima_depth++;
          end
        end
        held_values[value_depth] = w.push_value;
        value_depth++;
      end
    end else begin
      if (value_depth == 0) begin
        r.status = STATUS_POP_EMPTY;
      end else begin
        popped = held_values[value_depth-1];
        if (minima_depth > 0 && popped == held_minima[minima_depth-1]) minima_depth--;
        value_depth--;
        if (value_depth == 0) minima_depth = 0;
      end
    end
    if (value_depth == 0) begin
      r.top_value = '0;
      r.min_value = '0;
      r.is_empty  = 1'b1;
    end else begin
      r.top_value = held_values[value_depth-1];
      r.min_value = (minima_depth > 0) ? held_minima[minima_depth-1] : '0;
      r.is_empty  = 1'b0;
    end
    return r;
  endfunction

  // Mixes wide random values with small ones, extremes and repeats of the
  // current minimum so that ties on the minima stack happen often.
  function automatic logic signed [DataWidth-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: begin
        if (value_depth > 0 && minima_depth > 0) return held_minima[minima_depth-1];
        return $urandom;
      end
    endcase
  endfunction

  task automatic send_word(input logic cmd, input logic signed [DataWidth-1:0] value);
    stack_req_t w;
    int gap;
    w.command    = cmd;
    w.push_value = value;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(apply_command(w));
  endtask

  always @(posedge clk) begin
    stack_res_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: top %0d min %0d empty %0b status %0d",
                   result.top_value, result.min_value, result.is_empty, result.status);
      end else begin
        want = expected_results.pop_front();
        if (result.top_value !== want.top_value || result.min_value !== want.min_value ||
            result.is_empty !== want.is_empty || result.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("mismatch: expected top %0d min %0d empty %0b status %0d,",
                   want.top_value, want.min_value, want.is_empty, want.status);
            $display(" got top %0d min %0d empty %0b status %0d",
                     result.top_value, result.min_value, result.is_empty, result.status);
          end
        end
      end
    end
  end

  task automatic test_directed_corners();
    gap_max = 5;
    send_word(CMD_POP, 32'sh12345678);
    send_word(CMD_PUSH, 32'sh7fffffff);
    send_word(CMD_PUSH, 32'sh0);
    send_word(CMD_PUSH, 32'sh80000000);
    send_word(CMD_PUSH, 32'sh80000000);
    send_word(CMD_PUSH, -32'sd1);
    send_word(CMD_POP, 32'sh80000000);
    send_word(CMD_POP, 32'sh7fffffff);
    send_word(CMD_POP, -32'sd1);
    send_word(CMD_POP, 32'sh0);
    send_word(CMD_POP, 32'sh55555555);
    send_word(CMD_POP, 32'shaaaaaaaa);
  endtask

  // Fills the stack past its top so that pushes are refused, then drains it
  // past the bottom so that pops are refused.
  task automatic test_fill_drain(input int rounds);
    repeat (rounds) begin
      gap_max = ($urandom_range(0, 1) == 0) ? 0 : 19;
      repeat (Depth + 3) send_word(CMD_PUSH, pick_value());
      send_word(CMD_PUSH, 32'sh80000000);
      repeat (Depth + 2) send_word(CMD_POP, $urandom);
    end
  endtask

  // Wanders over the whole depth range with phases that lean to pushes, to pops
  // or to neither, and with varying idle gaps between command words.
  task automatic test_random_walk(input int segments);
    int push_percent;
    repeat (segments) begin
      case ($urandom_range(0, 2))
        0: push_percent = 25;
        1: push_percent = 50;
        default: push_percent = 80;
      endcase
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 19;
      endcase
      repeat (50) begin
        if ($urandom_range(1, 100) <= push_percent)
          send_word(CMD_PUSH, pick_value());
        else
          send_word(CMD_POP, $urandom);
      end
    end
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_fill_drain(3);
    test_random_walk(15);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
